/* design/petb_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the timer bank.
package petb_pkg;

  localparam int NUM_TIMERS = 4;
  // Bits that address one timer slot internally.
  localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  // Wide enough for the bank size (up to 8) and the in-use count.
  localparam int CNT_W = 4;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 2;
  localparam int TIME_W    = 32;
  localparam int INUSE_W   = 3;
  localparam int MASK_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_PERIOD_REGS = 4;

  localparam int IN_TDATA_W  = ((IDX_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * MASK_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_USE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = 3'd1;

  localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1000;

  typedef struct packed {
    logic load;  // capture the accepted transaction, restart the walk
    logic step;  // examine one timer of a tick
    logic exec;  // apply a run or stop command
    logic emit;  // write the result register
  } petb_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic walk_last;
    logic out_free;
  } petb_stat_t;

endpackage

/* design/periodic_event_timer_bank.sv */
// Top level of the periodic event timer bank: controller plus datapath.
//
//  channel  direction  handshake             payload
//  in_      slave      in_tvalid/in_tready   in_tuser opcode, in_tdata index + time
//  out_     master     out_tvalid/out_tready out_tdata fire mask + enabled mask
//  cfg_     slave      cfg_valid/cfg_ready   cfg_index register, cfg_data value
//
// A tick is accepted while the controller idles; the walk then visits the timers one by
// one through a single subtract-and-compare unit, and last the result register is
// loaded. Run, stop and the unused opcode are accepted, applied, and then loaded into
// the result register. in_tready is high only while the controller idles, so one
// transaction is in work at a time; a result held by out_tready low does not stop
// the next transaction from being accepted, only its result write waits.
// rst_n is synchronous: it disables all timers, clears their last fire times, sets
// the in-use count to zero and every period to 1000. cfg_ready is always high.
module periodic_event_timer_bank (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input transactions.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [petb_pkg::OP_W-1:0]            in_tuser,   // [1:0] opcode
  input  logic [petb_pkg::IN_TDATA_W-1:0]      in_tdata,   // [1:0] timer_index,
                                                           // [33:2] now_time, rest zero
  // Result transactions.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [petb_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [3:0] fire_mask,
                                                           // [7:4] enabled_mask
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [petb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [petb_pkg::TIME_W-1:0]          cfg_data
);
  import petb_pkg::*;

  petb_cmd_t  cmd;
  petb_stat_t stat;

  // The user must issue writes only while idle; the block does not enforce this and accepts them unconditionally.
  assign cfg_ready = 1'b1;

  petb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  petb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/petb_ctrl.sv */
// Controller state machine of the timer bank.
module petb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  petb_pkg::petb_stat_t  stat,
  output petb_pkg::petb_cmd_t   cmd
);
  import petb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.is_tick) begin
          cmd.step = 1'b1;
          if (stat.walk_last) state_nxt = S_EMIT;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* design/petb_dp.sv */
// Datapath of the timer bank: configuration, timer state, walk and result register.
module petb_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  petb_pkg::petb_cmd_t                  cmd,
  output petb_pkg::petb_stat_t                 stat,
  input  logic [petb_pkg::OP_W-1:0]            in_tuser,
  input  logic [petb_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 cfg_we,
  input  logic [petb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [petb_pkg::TIME_W-1:0]          cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [petb_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import petb_pkg::*;

  logic [INUSE_W-1:0]    in_use_r;
  logic [TIME_W-1:0]     period_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] en_r;
  logic [NUM_TIMERS-1:0] fire_r;
  logic [TIME_W-1:0]     last_r [NUM_TIMERS];
  logic [OP_W-1:0]       op_r;
  logic [IDX_W-1:0]      idx_r;
  logic [TIME_W-1:0]     now_r;
  logic [TIDX_W-1:0]     walk_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [CNT_W-1:0]  live;
  logic [TIDX_W-1:0] cmd_slot;
  logic              cmd_ok;
  logic [TIME_W-1:0] elapsed;
  logic              hit;
  logic [MASK_W-1:0] fire_m;
  logic [MASK_W-1:0] en_m;

  // In-use counts above the bank size act as the bank size.
  assign live = (CNT_W'(in_use_r) > CNT_W'(NUM_TIMERS)) ? CNT_W'(NUM_TIMERS)
                                                         : CNT_W'(in_use_r);
  assign cmd_slot = TIDX_W'(idx_r);
  assign cmd_ok   = CNT_W'(idx_r) < live;
  // Wrapping subtraction gives elapsed time across a counter rollover.
  assign elapsed  = now_r - last_r[walk_r];
  assign hit      = en_r[walk_r] && (CNT_W'(walk_r) < live) && (elapsed >= period_r[walk_r]);

  always_comb begin
    fire_m = '0;
    en_m   = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < NUM_TIMERS) begin
        fire_m[b] = fire_r[b];
        en_m[b]   = en_r[b];
      end
    end
  end

  assign stat.is_tick   = (op_r == OP_TICK);
  assign stat.walk_last = (walk_r == TIDX_W'(NUM_TIMERS - 1));
  assign stat.out_free  = !out_valid_r || out_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) period_r[t] <= PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_IN_USE) in_use_r <= cfg_data[INUSE_W-1:0];
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (t < NUM_PERIOD_REGS && cfg_index == REG_PERIOD_BASE + CFG_IDX_W'(t))
          period_r[t] <= cfg_data;
      end
    end
  end

  // Timer state, walk position and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      fire_r      <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TIMERS; t++) last_r[t] <= '0;
    end else begin
      if (cmd.load) begin
        walk_r <= '0;
        fire_r <= '0;
      end
      if (cmd.step) begin
        walk_r <= walk_r + 1'b1;
        if (hit) begin
          fire_r[walk_r] <= 1'b1;
          last_r[walk_r] <= now_r;
        end
      end
      if (cmd.exec && cmd_ok) begin
        case (op_r)
          OP_RUN: begin
            en_r[cmd_slot]   <= 1'b1;
            last_r[cmd_slot] <= now_r;
          end
          OP_STOP: en_r[cmd_slot] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload captures.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tuser;
      idx_r <= in_tdata[IDX_W-1:0];
      now_r <= in_tdata[IDX_W +: TIME_W];
    end
    if (cmd.emit) out_data_r <= OUT_TDATA_W'({en_m, fire_m});
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/petb_checker.sv */
// Port-level checks of the timer bank, bound to the top level.
module petb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [petb_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import petb_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // Drop any result after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // One transaction in work: busy the cycle after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted back to back");

  // A timer that fired is still enabled.
  a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[MASK_W-1:0] & ~out_tdata[2*MASK_W-1:MASK_W]) == '0)
    else $error("fire bit set for a disabled timer");

endmodule

bind periodic_event_timer_bank petb_checker u_petb_checker (.*);
